FILE: rtl/sha1_stream_hash_defines.svh
// ----------------------------------------------------------------------------
// SHA-1 stream hasher: assertion macros
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef SHA1_STREAM_HASH_DEFINES_SVH
`define SHA1_STREAM_HASH_DEFINES_SVH

// checked only outside reset
`define SHA1S_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define SHA1S_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/sha1s_pkg.sv
// ----------------------------------------------------------------------------
// SHA-1 stream hasher: package
// Shared types, constants and round functions.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1s_pkg;

  localparam int CNT_W = 61;

  localparam logic CMD_ABSORB = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [31:0] H_INIT [5] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  localparam logic [31:0] K_ROUND [4] = '{
    32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc, 32'hca62c1d6
  };

  typedef logic [4:0][31:0] digest_t;

  typedef enum logic [1:0] {
    SRC_IN,
    SRC_PAD80,
    SRC_ZERO,
    SRC_LEN
  } byte_src_t;

  typedef struct packed {
    logic      shift_byte;
    byte_src_t src;
    logic [2:0] len_idx;
    logic      count_inc;
    logic      len_capture;
    logic      comp_load;
    logic      round;
    logic [1:0] phase;
    logic      chain_add;
    logic      digest_load;
  } dp_cmd_t;

  function automatic logic [31:0] f_round(input logic [1:0] phase,
                                          input logic [31:0] b,
                                          input logic [31:0] c,
                                          input logic [31:0] d);
    logic [31:0] res;
    case (phase)
      2'd0:    res = (b & c) | (~b & d);
      2'd2:    res = (b & c) | (b & d) | (c & d);
      default: res = b ^ c ^ d;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/sha1s_if.sv
// ----------------------------------------------------------------------------
// SHA-1 stream hasher: channel interfaces
// Valid/ready channels for input words and digest words.
// ----------------------------------------------------------------------------
`default_nettype none

interface sha1s_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] data_byte;

  modport source (output valid, output cmd, output data_byte, input ready);
  modport sink (input valid, input cmd, input data_byte, output ready);
endinterface

interface sha1s_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last;

  modport source (output valid, output digest_word, output word_index, output last,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input last,
                output ready);
endinterface

`default_nettype wire

FILE: rtl/sha1s_ctrl.sv
// ----------------------------------------------------------------------------
// SHA-1 stream hasher: controller
// Sequences byte loading, padding, the 80 rounds and the digest hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1s_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_cmd,
  output logic              in_ready,
  input  logic              out_busy,
  output sha1s_pkg::dp_cmd_t cmd
);
  import sha1s_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PAD,
    S_COMP,
    S_ADD
  } state_t;

  state_t     state_r, state_nxt;
  logic [5:0] fill_r, fill_nxt;
  logic [4:0] sub_r, sub_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic       first_r, first_nxt;
  logic       final_r, final_nxt;
  logic       pad_r, pad_nxt;

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    fill_nxt  = fill_r;
    sub_nxt   = sub_r;
    phase_nxt = phase_r;
    first_nxt = first_r;
    final_nxt = final_r;
    pad_nxt   = pad_r;
    cmd.phase   = phase_r;
    cmd.len_idx = fill_r[2:0];
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_cmd == CMD_ABSORB) begin
            cmd.shift_byte = 1'b1;
            cmd.src        = SRC_IN;
            cmd.count_inc  = 1'b1;
            fill_nxt       = fill_r + 6'd1;
            pad_nxt        = 1'b0;
            if (fill_r == 6'd63) begin
              cmd.comp_load = 1'b1;
              sub_nxt       = '0;
              phase_nxt     = '0;
              state_nxt     = S_COMP;
            end
          end else begin
            cmd.len_capture = 1'b1;
            first_nxt       = 1'b1;
            pad_nxt         = 1'b1;
            final_nxt       = (fill_r[5:3] != 3'b111);
            state_nxt       = S_PAD;
          end
        end
      end
      S_PAD: begin
        cmd.shift_byte = 1'b1;
        if (first_r) begin
          cmd.src = SRC_PAD80;
        end else if (final_r && (fill_r[5:3] == 3'b111)) begin
          cmd.src = SRC_LEN;
        end else begin
          cmd.src = SRC_ZERO;
        end
        first_nxt = 1'b0;
        fill_nxt  = fill_r + 6'd1;
        if (fill_r == 6'd63) begin
          cmd.comp_load = 1'b1;
          sub_nxt       = '0;
          phase_nxt     = '0;
          state_nxt     = S_COMP;
        end
      end
      S_COMP: begin
        cmd.round = 1'b1;
        if (sub_r == 5'd19) begin
          sub_nxt   = '0;
          phase_nxt = phase_r + 2'd1;
          if (phase_r == 2'd3) begin
            state_nxt = S_ADD;
          end
        end else begin
          sub_nxt = sub_r + 5'd1;
        end
      end
      S_ADD: begin
        if (!pad_r) begin
          cmd.chain_add = 1'b1;
          state_nxt     = S_IDLE;
        end else if (!final_r) begin
          cmd.chain_add = 1'b1;
          final_nxt     = 1'b1;
          state_nxt     = S_PAD;
        end else if (!out_busy) begin
          cmd.digest_load = 1'b1;
          pad_nxt         = 1'b0;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      sub_r   <= '0;
      phase_r <= '0;
      first_r <= 1'b0;
      final_r <= 1'b0;
      pad_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      sub_r   <= sub_nxt;
      phase_r <= phase_nxt;
      first_r <= first_nxt;
      final_r <= final_nxt;
      pad_r   <= pad_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sha1s_dp.sv
// ----------------------------------------------------------------------------
// SHA-1 stream hasher: datapath
// Message window, round registers, chaining words and byte count.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1s_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  sha1s_pkg::dp_cmd_t cmd,
  input  logic [7:0]         in_byte,
  output sha1s_pkg::digest_t digest
);
  import sha1s_pkg::*;

  // 16-word schedule window, W[t] in the top word
  logic [511:0]     win_r, win_nxt;
  logic [63:0]      len_r;
  logic [CNT_W-1:0] count_r;
  digest_t          wk_r;
  digest_t          chain_r;

  logic [7:0]  byte_sel;
  logic [2:0]  len_pos;
  logic [31:0] w0, w2, w8, w13, w_new, t_sum;

  assign len_pos = ~cmd.len_idx;

  always_comb begin
    case (cmd.src)
      SRC_IN:    byte_sel = in_byte;
      SRC_PAD80: byte_sel = PAD_BYTE;
      SRC_LEN:   byte_sel = len_r[{len_pos, 3'b000} +: 8];
      default:   byte_sel = 8'h00;
    endcase
  end

  assign w0    = win_r[511:480];
  assign w2    = win_r[447:416];
  assign w8    = win_r[255:224];
  assign w13   = win_r[95:64];
  assign t_sum = w13 ^ w8 ^ w2 ^ w0;
  assign w_new = {t_sum[30:0], t_sum[31]};

  always_comb begin
    win_nxt = win_r;
    if (cmd.shift_byte) begin
      win_nxt = {win_r[503:0], byte_sel};
    end else if (cmd.round) begin
      win_nxt = {win_r[479:0], w_new};
    end
  end

  logic [31:0] a_new;
  assign a_new = {wk_r[0][26:0], wk_r[0][31:27]}
               + f_round(cmd.phase, wk_r[1], wk_r[2], wk_r[3])
               + wk_r[4] + w0 + K_ROUND[cmd.phase];

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      digest[i] = chain_r[i] + wk_r[i];
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    if (cmd.len_capture) begin
      len_r <= {count_r, 3'b000};
    end
    if (cmd.comp_load) begin
      wk_r <= chain_r;
    end else if (cmd.round) begin
      wk_r[0] <= a_new;
      wk_r[1] <= wk_r[0];
      wk_r[2] <= {wk_r[1][1:0], wk_r[1][31:2]};
      wk_r[3] <= wk_r[2];
      wk_r[4] <= wk_r[3];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      for (int i = 0; i < 5; i++) begin
        chain_r[i] <= H_INIT[i];
      end
    end else begin
      if (cmd.digest_load) begin
        count_r <= '0;
        for (int i = 0; i < 5; i++) begin
          chain_r[i] <= H_INIT[i];
        end
      end else begin
        if (cmd.count_inc) begin
          count_r <= count_r + {{(CNT_W-1){1'b0}}, 1'b1};
        end
        if (cmd.chain_add) begin
          chain_r <= digest;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sha1s_outq.sv
// ----------------------------------------------------------------------------
// SHA-1 stream hasher: digest output register
// Holds a finished digest and hands it out one word per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1s_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  sha1s_pkg::digest_t digest,
  output logic               busy,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_digest_word,
  output logic [2:0]         out_word_index,
  output logic               out_last
);
  import sha1s_pkg::*;

  digest_t    words_r;
  logic       valid_r;
  logic [2:0] idx_r;
  logic       take;

  assign take            = valid_r && out_ready;
  assign busy            = valid_r;
  assign out_valid       = valid_r;
  assign out_digest_word = words_r[0];
  assign out_word_index  = idx_r;
  assign out_last        = (idx_r == 3'd4);

  always_ff @(posedge clk) begin
    if (load) begin
      words_r <= digest;
    end else if (take) begin
      words_r <= {32'h0, words_r[4:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (load) begin
      valid_r <= 1'b1;
      idx_r   <= '0;
    end else if (take) begin
      idx_r <= idx_r + 3'd1;
      if (idx_r == 3'd4) begin
        valid_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sha1_stream_hash.sv
// ----------------------------------------------------------------------------
// SHA-1 stream hasher: top level
// Absorbs a message one byte per word and returns the 160-bit digest as five
// 32-bit words, H0 first, the fifth marked last.
// ----------------------------------------------------------------------------
// The 64th byte of a block starts the compression: 80 rounds on the single
// round unit, then the chaining add, during which in_ch.ready is low. A
// finish word writes the padding and length one byte per cycle up to the
// end of the block, compresses, and when fewer than nine bytes were free
// does a second padding block and compression; the digest is then moved to
// the output register, the hasher returns to its initial state and input
// is taken again while the five digest words drain, one per cycle in which
// out_ch.ready is high. The hand-off of a finished digest waits for the
// previous digest to drain.
`default_nettype none

module sha1_stream_hash (
  input  logic       clk,
  input  logic       rst_n,
  sha1s_in_if.sink   in_ch,
  sha1s_out_if.source out_ch
);
  import sha1s_pkg::*;

  dp_cmd_t cmd;
  digest_t digest;
  logic    out_busy;

  sha1s_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_cmd   (in_ch.cmd),
    .in_ready (in_ch.ready),
    .out_busy (out_busy),
    .cmd      (cmd)
  );

  sha1s_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_byte (in_ch.data_byte),
    .digest  (digest)
  );

  sha1s_outq u_outq (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (cmd.digest_load),
    .digest          (digest),
    .busy            (out_busy),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_digest_word (out_ch.digest_word),
    .out_word_index  (out_ch.word_index),
    .out_last        (out_ch.last)
  );

endmodule

`default_nettype wire

FILE: rtl/sha1s_checker.sv
// ----------------------------------------------------------------------------
// SHA-1 stream hasher: port checker
// Checks digest word sequencing as seen on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sha1_stream_hash_defines.svh"

module sha1s_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] word_index,
  input logic       last
);

  `SHA1S_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid, "output valid after reset")
  `SHA1S_ASSERT(a_last_marks_four, out_valid |-> (last == (word_index == 3'd4)), "last mismatch")
  `SHA1S_ASSERT(a_starts_at_zero, $rose(out_valid) |-> (word_index == 3'd0), "digest not at H0")
  `SHA1S_ASSERT(a_index_steps, (out_valid && out_ready && !last) |=>
    (out_valid && (word_index == $past(word_index) + 3'd1)), "digest word skipped")

endmodule

bind sha1_stream_hash sha1s_checker u_sha1s_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .word_index (out_ch.word_index),
  .last       (out_ch.last)
);

`default_nettype wire

FILE: test/sha1_stream_hash_tb.sv
// ----------------------------------------------------------------------------
// SHA-1 stream hasher: testbench
// Streams messages a byte per word, then a finish word, and checks each of
// the five digest words against a behavioral SHA-1 kept in the bench.
// Directed messages come first: the empty message, "abc", and extreme and
// pad byte values. Random messages follow in three idle phases. Their
// lengths favor block and padding boundaries, including the two-block pad.
// ----------------------------------------------------------------------------
module sha1_stream_hash_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sha1s_pkg::*;

  typedef struct {
    logic       cmd;
    logic [7:0] data;
  } hash_word_t;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  logic clk;
  logic rst_n;

  sha1s_in_if  in_ch ();
  sha1s_out_if out_ch ();

  sha1_stream_hash DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  hash_word_t   pending_words[$];
  digest_word_t expected_digest[$];
  int           mismatch_count = 0;
  int           src_idle_pct = 0;
  int           sink_idle_pct = 0;

  // bench copy of the hasher state
  logic [7:0]  blk_bytes [64];
  int          blk_fill;
  logic [31:0] chain [5];
  logic [60:0] msg_len;

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_ABSORB;
    in_ch.data_byte = 8'h00;
    out_ch.ready = 1'b0;
  end

  always #5 clk = ~clk;

  task automatic reset_hasher();
    blk_fill = 0;
    msg_len = '0;
    for (int i = 0; i < 5; i++) chain[i] = H_INIT[i];
  endtask

  task automatic compress_block();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t, x;
    for (int r = 0; r < 16; r++) begin
      w[r] = {blk_bytes[4*r], blk_bytes[4*r+1], blk_bytes[4*r+2], blk_bytes[4*r+3]};
    end
    for (int r = 16; r < 80; r++) begin
      x = w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16];
      w[r] = {x[30:0], x[31]};
    end
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    e = chain[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = K_ROUND[0];
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = K_ROUND[1];
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K_ROUND[2];
      end else begin
        f = b ^ c ^ d;
        k = K_ROUND[3];
      end
      t = {a[26:0], a[31:27]} + f + e + k + w[r];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    chain[0] = chain[0] + a;
    chain[1] = chain[1] + b;
    chain[2] = chain[2] + c;
    chain[3] = chain[3] + d;
    chain[4] = chain[4] + e;
  endtask

  task automatic hash_word(hash_word_t hw);
    logic [63:0]  bit_len;
    int           i;
    digest_word_t dw;
    if (hw.cmd == CMD_ABSORB) begin
      blk_bytes[blk_fill] = hw.data;
      blk_fill++;
      msg_len = msg_len + 61'd1;
      if (blk_fill == 64) begin
        compress_block();
        blk_fill = 0;
      end
    end else begin
      bit_len = {msg_len, 3'b000};
      i = blk_fill;
      blk_bytes[i] = PAD_BYTE;
      i++;
      if (i > 56) begin
        while (i < 64) begin
          blk_bytes[i] = 8'h00;
          i++;
        end
        compress_block();
        i = 0;
      end
      while (i < 56) begin
        blk_bytes[i] = 8'h00;
        i++;
      end
      for (int j = 0; j < 8; j++) blk_bytes[56+j] = bit_len[63-8*j -: 8];
      compress_block();
      for (int j = 0; j < 5; j++) begin
        dw.word = chain[j];
        dw.idx = 3'(j);
        dw.last = (j == 4);
        expected_digest.push_back(dw);
      end
      reset_hasher();
    end
  endtask

  task automatic push_word(logic cmd, logic [7:0] data);
    hash_word_t hw;
    hw.cmd = cmd;
    hw.data = data;
    pending_words.push_back(hw);
  endtask

  task automatic push_message(int len);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 7))
        0:       b = 8'h00;
        1:       b = 8'hff;
        default: b = 8'($urandom_range(0, 255));
      endcase
      push_word(CMD_ABSORB, b);
    end
    push_word(CMD_FINISH, 8'($urandom_range(0, 255)));
  endtask

  function automatic int pick_length();
    int edges [8] = '{55, 56, 57, 63, 64, 65, 119, 120};
    if ($urandom_range(0, 2) == 0) return edges[$urandom_range(0, 7)];
    return $urandom_range(0, 30);
  endfunction

  task automatic wait_drained();
    while (pending_words.size() > 0 || expected_digest.size() > 0) @(posedge clk);
  endtask

  task automatic run_phase(int src_pct, int sink_pct);
    int count;
    int len;
    wait_drained();
    src_idle_pct = src_pct;
    sink_idle_pct = sink_pct;
    count = 0;
    while (count < 88) begin
      len = pick_length();
      push_message(len);
      count += len + 1;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) hash_word(pending_words.pop_front());
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_words.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.cmd <= pending_words[0].cmd;
          in_ch.data_byte <= pending_words[0].data;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    digest_word_t dw;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_digest.size() == 0) begin
          $display("%0t unexpected digest word: expected none, actual %h idx %0d last %0b",
                   $time, out_ch.digest_word, out_ch.word_index, out_ch.last);
          mismatch_count++;
        end else begin
          dw = expected_digest.pop_front();
          if (out_ch.digest_word !== dw.word) begin
            $display("%0t digest_word: expected %h actual %h", $time, dw.word,
                     out_ch.digest_word);
            mismatch_count++;
          end
          if (out_ch.word_index !== dw.idx) begin
            $display("%0t word_index: expected %0d actual %0d", $time, dw.idx,
                     out_ch.word_index);
            mismatch_count++;
          end
          if (out_ch.last !== dw.last) begin
            $display("%0t last: expected %0b actual %0b", $time, dw.last, out_ch.last);
            mismatch_count++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  initial begin
    reset_hasher();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // empty message, "abc", extreme bytes, lone pad byte, empty again
    push_word(CMD_FINISH, 8'hff);
    push_word(CMD_ABSORB, 8'h61);
    push_word(CMD_ABSORB, 8'h62);
    push_word(CMD_ABSORB, 8'h63);
    push_word(CMD_FINISH, 8'h00);
    push_word(CMD_ABSORB, 8'h00);
    push_word(CMD_ABSORB, 8'hff);
    push_word(CMD_FINISH, 8'h5a);
    push_word(CMD_ABSORB, PAD_BYTE);
    push_word(CMD_FINISH, 8'h00);
    push_word(CMD_FINISH, 8'h00);

    run_phase(21, 71);
    run_phase(71, 21);
    run_phase(0, 0);
    wait_drained();
    repeat (200) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #(2_000_000);
    $display("%0t timeout", $time);
    $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/sha1s_pkg.sv
rtl/sha1s_if.sv
rtl/sha1s_ctrl.sv
rtl/sha1s_dp.sv
rtl/sha1s_outq.sv
rtl/sha1_stream_hash.sv
rtl/sha1s_checker.sv
test/sha1_stream_hash_tb.sv
